/* rtl/vadl_pkg.sv */
// shared types and constants for the acceleration and braking limit block
`default_nettype none

package vadl_pkg;

  // configuration register map, one word per register
  typedef enum logic [2:0] {
    REG_WHEEL_RADIUS      = 3'd0,
    REG_PEAK_POWER        = 3'd1,
    REG_PEAK_TORQUE       = 3'd2,
    REG_ZERO_TORQUE_SPEED = 3'd3,
    REG_POWER_LIMIT_SPEED = 3'd4,
    REG_DRAG_COEFFICIENT  = 3'd5,
    REG_ROLLING_FORCE     = 3'd6,
    REG_VEHICLE_MASS      = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    FORCE_ZERO   = 2'd0,
    FORCE_TORQUE = 2'd1,
    FORCE_POWER  = 2'd2,
    FORCE_TAPER  = 2'd3
  } force_sel_e;

  typedef struct packed {
    logic [10:0] wheel_radius;
    logic [19:0] peak_power;
    logic [12:0] peak_torque;
    logic [15:0] zero_torque_speed;
    logic [15:0] power_limit_speed;
    logic [15:0] drag_coefficient;
    logic [12:0] rolling_force;
    logic [12:0] vehicle_mass;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    wheel_radius:      11'd307,
    peak_power:        20'd100000,
    peak_torque:       13'd300,
    zero_torque_speed: 16'd4000,
    power_limit_speed: 16'd3000,
    drag_coefficient:  16'd26214,
    rolling_force:     13'd150,
    vehicle_mass:      13'd1500
  };

  // gravity in 1/65536 m/s^2
  localparam logic [19:0] GravQ16 = 20'd642908;
  // 0.001 m/s^2 at scale 2^-32
  localparam logic [22:0] EpsQ32  = 23'd4294967;
  localparam logic [12:0] OutMax  = 13'd8191;

  // front end result
  typedef struct packed {
    logic [57:0] sqx;
    logic [62:0] num;
    logic [42:0] den;
    logic [24:0] resist;
    logic        safe;
    logic        near;
    logic [28:0] fr24;
    logic [12:0] acap;
    logic [12:0] dcap;
  } front_t;

  typedef struct packed {
    logic [62:0] num;
    logic [42:0] den;
    logic [24:0] resist;
    logic        safe;
    logic        near;
    logic [28:0] fr24;
    logic [12:0] acap;
    logic [12:0] dcap;
  } sq_side_t;

  typedef struct packed {
    logic [28:0] root;
    logic [24:0] resist;
    logic        safe;
    logic        near;
    logic [28:0] fr24;
    logic [12:0] acap;
    logic [12:0] dcap;
  } fd_side_t;

  typedef struct packed {
    logic        gate;
    logic [12:0] decel;
    logic        safe;
    logic [12:0] acap;
    logic [12:0] frcap;
  } acc_side_t;

  typedef struct packed {
    logic [35:0] net;
    acc_side_t   acc;
  } qd_side_t;

  typedef struct packed {
    logic      sat;
    acc_side_t acc;
  } ad_side_t;

endpackage

`default_nettype wire

/* rtl/vadl_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module vadl_div_pipe #(
  parameter int unsigned NUM_W  = 32,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned Q_W    = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // caller guarantees the quotient fits in Q_W bits
  logic [Q_W-1:0]    vld_q;
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  logic [DEN_W-1:0]  rem_in  [Q_W];
  logic [Q_W-1:0]    low_in  [Q_W];
  logic [Q_W-1:0]    quo_in  [Q_W];
  logic [DEN_W-1:0]  den_in  [Q_W];
  logic [SIDE_W-1:0] side_in [Q_W];

  logic [DEN_W-1:0]  rem_d [Q_W];
  logic [Q_W-1:0]    low_d [Q_W];
  logic [Q_W-1:0]    quo_d [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in[k]  = DEN_W'(num_i >> Q_W);
      assign low_in[k]  = num_i[Q_W-1:0];
      assign quo_in[k]  = '0;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign low_in[k]  = low_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    assign trial    = {rem_in[k], low_in[k][Q_W-1]};
    assign diff     = trial - {1'b0, den_in[k]};
    assign take     = trial >= {1'b0, den_in[k]};
    assign rem_d[k] = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign low_d[k] = {low_in[k][Q_W-2:0], 1'b0};
    assign quo_d[k] = {quo_in[k][Q_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

`default_nettype wire

/* rtl/vadl_sqrt_pipe.sv */
// pipelined integer square root, one root bit per stage
`default_nettype none

module vadl_sqrt_pipe #(
  parameter int unsigned ROOT_W = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] x_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned X_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] vld_q;
  logic [ROOT_W:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [X_W-1:0]    xl_q   [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  logic [ROOT_W:0]   rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [X_W-1:0]    xl_in   [ROOT_W];
  logic [SIDE_W-1:0] side_in [ROOT_W];

  logic [ROOT_W:0]   rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];
  logic [X_W-1:0]    xl_d   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign xl_in[k]   = x_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign xl_in[k]   = xl_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // bring down two bits, try 4*root+1
    assign cur       = {rem_in[k], xl_in[k][X_W-1:X_W-2]};
    assign trial     = {1'b0, root_in[k], 2'b01};
    assign diff      = cur - trial;
    assign take      = cur >= trial;
    assign rem_d[k]  = take ? diff[ROOT_W:0] : cur[ROOT_W:0];
    assign root_d[k] = {root_in[k][ROOT_W-2:0], take};
    assign xl_d[k]   = {xl_in[k][X_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        xl_q[k]   <= xl_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/vadl_front.sv */
// front end: products, torque region, resistance and friction budget
`default_nettype none

module vadl_front import vadl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cfg_t        cfg_i,
  input  logic [15:0] speed_i,
  input  logic [16:0] curv_i,
  input  logic [8:0]  mu_i,
  input  logic [12:0] acap_i,
  input  logic [12:0] dcap_i,
  output logic        valid_o,
  output front_t      front_o
);

  logic [10:0] r_eff;
  logic [16:0] k_d;

  logic [4:0]  vld_q;

  // stage 1
  logic [15:0] s1_q;
  logic [16:0] k1_q;
  logic [8:0]  mu1_q;
  logic [12:0] acap1_q, dcap1_q;

  // stage 2
  logic [15:0] s2_q;
  logic        sz2_q;
  logic [21:0] a2_q;
  logic [26:0] bn2_q, bm2_q;
  logic [31:0] ssq2_q;
  logic [30:0] ppr2_q, spt2_q;
  logic [28:0] fr2_q;
  logic [16:0] k2_q;
  logic [12:0] acap2_q, dcap2_q;

  // stage 3
  force_sel_e  sel_d, sel3_q;
  logic [15:0] s3_q;
  logic [46:0] ppd3_q;
  logic [31:0] sdz3_q;
  logic [48:0] rad3_q;
  logic [47:0] drs3_q;
  logic [28:0] fr3_q;
  logic [12:0] acap3_q, dcap3_q;

  // stage 4
  logic [62:0] num_d, num4_q;
  logic [42:0] den_d, den4_q;
  logic [24:0] resist4_q;
  logic        safe_d, safe4_q, near4_q;
  logic [36:0] fr32;
  logic [40:0] rad24;
  logic [28:0] diff_d, diff4_q;
  logic [29:0] sum_d, sum4_q;
  logic [28:0] fr4_q;
  logic [12:0] acap4_q, dcap4_q;

  // stage 5
  logic [58:0] sq_prod;
  front_t      front5_q;

  assign r_eff = (cfg_i.wheel_radius == '0) ? 11'd1 : cfg_i.wheel_radius;
  assign k_d   = curv_i[16] ? (17'd0 - curv_i) : curv_i;

  // torque curve region, exact compares against 64*speed
  always_comb begin
    priority if (a2_q >= 22'(bn2_q) && bn2_q[26:22] == '0) begin
      sel_d = FORCE_ZERO;
    end else if (sz2_q) begin
      sel_d = FORCE_TORQUE;
    end else if (27'(a2_q) >= bm2_q) begin
      sel_d = FORCE_TAPER;
    end else if (ppr2_q >= spt2_q) begin
      sel_d = FORCE_TORQUE;
    end else begin
      sel_d = FORCE_POWER;
    end
  end

  always_comb begin
    unique case (sel3_q)
      FORCE_ZERO: begin
        num_d = '0;
        den_d = 43'd1;
      end
      FORCE_TORQUE: begin
        num_d = 63'({cfg_i.peak_torque, 18'd0});
        den_d = 43'(r_eff);
      end
      FORCE_POWER: begin
        num_d = 63'({cfg_i.peak_power, 16'd0});
        den_d = 43'(s3_q);
      end
      FORCE_TAPER: begin
        num_d = {ppd3_q, 16'd0};
        den_d = 43'(sdz3_q) * 43'(r_eff);
      end
      default: begin
        num_d = '0;
        den_d = 43'd1;
      end
    endcase
  end

  assign fr32   = {fr3_q, 8'd0};
  assign safe_d = rad3_q <= 49'(fr32);
  assign rad24  = rad3_q[48:8];
  // with a safe point rad24 never exceeds fr24
  assign diff_d = safe_d ? (fr3_q - rad24[28:0]) : '0;
  assign sum_d  = safe_d ? (30'(fr3_q) + 30'(rad24[28:0])) : '0;

  assign sq_prod = 59'(diff4_q) * 59'(sum4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= speed_i;
      k1_q    <= k_d;
      mu1_q   <= mu_i;
      acap1_q <= acap_i;
      dcap1_q <= dcap_i;

      s2_q    <= s1_q;
      sz2_q   <= (s1_q == '0);
      a2_q    <= {s1_q, 6'd0};
      bn2_q   <= 27'(cfg_i.zero_torque_speed) * 27'(r_eff);
      bm2_q   <= 27'(cfg_i.power_limit_speed) * 27'(r_eff);
      ssq2_q  <= 32'(s1_q) * 32'(s1_q);
      ppr2_q  <= 31'(cfg_i.peak_power) * 31'(r_eff);
      spt2_q  <= {29'(s1_q) * 29'(cfg_i.peak_torque), 2'b00};
      fr2_q   <= 29'(mu1_q) * 29'(GravQ16);
      k2_q    <= k1_q;
      acap2_q <= acap1_q;
      dcap2_q <= dcap1_q;

      sel3_q  <= sel_d;
      s3_q    <= s2_q;
      ppd3_q  <= 47'(cfg_i.peak_power) * 47'(bn2_q - 27'(a2_q));
      sdz3_q  <= 32'(s2_q) * 32'(cfg_i.zero_torque_speed - cfg_i.power_limit_speed);
      rad3_q  <= 49'(k2_q) * 49'(ssq2_q);
      drs3_q  <= 48'(cfg_i.drag_coefficient) * 48'(ssq2_q);
      fr3_q   <= fr2_q;
      acap3_q <= acap2_q;
      dcap3_q <= dcap2_q;

      num4_q    <= num_d;
      den4_q    <= den_d;
      resist4_q <= 25'(drs3_q[47:24]) + 25'({cfg_i.rolling_force, 8'd0});
      safe4_q   <= safe_d;
      near4_q   <= rad3_q <= (49'(fr32) + 49'(EpsQ32));
      diff4_q   <= diff_d;
      sum4_q    <= sum_d;
      fr4_q     <= fr3_q;
      acap4_q   <= acap3_q;
      dcap4_q   <= dcap3_q;

      front5_q.sqx    <= sq_prod[57:0];
      front5_q.num    <= num4_q;
      front5_q.den    <= den4_q;
      front5_q.resist <= resist4_q;
      front5_q.safe   <= safe4_q;
      front5_q.near   <= near4_q;
      front5_q.fr24   <= fr4_q;
      front5_q.acap   <= acap4_q;
      front5_q.dcap   <= dcap4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign front_o = front5_q;

endmodule

`default_nettype wire

/* rtl/vehicle_accel_decel_limits_core.sv */
// acceleration and braking limits per trajectory point, top level
// throughput: one request per cycle while no result is held back on m_axis; the depth
// is set by the 5-stage front end, the 29-stage square root, the 36-stage force divider
// and the 17- and 13-stage ratio and mass dividers in series, plus three single stages
// and the output register; the user must change configuration registers only with the
// pipe empty, which the block leaves to the user, since stages along the pipe read them
// reset: asynchronous, active low; clears all valid bits and loads the register defaults
`default_nettype none

module vehicle_accel_decel_limits_core import vadl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] speed, [32:16] path_curvature, [41:33] friction_mu,
  // [54:42] accel_cap, [67:55] decel_cap, [71:68] zero
  input  logic [71:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] max_accel, [25:13] max_decel, [26] braking_safe, [31:27] zero
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned SqSideW = $bits(sq_side_t);
  localparam int unsigned FdSideW = $bits(fd_side_t);
  localparam int unsigned QdSideW = $bits(qd_side_t);
  localparam int unsigned AdSideW = $bits(ad_side_t);

  // configuration registers
  cfg_t        cfg_q;
  reg_idx_e    reg_idx;
  logic [12:0] mass_eff;

  // pipeline advance: every stage up to the mass divider moves together
  logic        adv;

  // front end
  logic        fe_vld;
  front_t      fe;
  sq_side_t    sq_si, sq_so;

  // square root
  logic        sq_vld;
  logic [28:0] sq_root;
  fd_side_t    fd_si, fd_so;

  // force divider
  logic        fd_vld;
  logic [35:0] fd_quo;
  logic [35:0] net_d;
  logic [45:0] net_k;

  // ratio stage
  logic        m1_vld_q;
  qd_side_t    m1_q;
  logic [44:0] m1_num_q;
  logic [28:0] m1_den_q;
  logic        qd_vld;
  logic [16:0] qd_quo;
  qd_side_t    qd_so;

  // product and saturation stages
  logic        m2_vld_q;
  logic [52:0] m2_prod_q;
  acc_side_t   m2_q;
  logic [36:0] x_d;
  logic        sat_d;
  logic        m3_vld_q;
  logic [25:0] m3_num_q;
  ad_side_t    m3_q;

  // mass divider
  logic        ad_vld;
  logic [12:0] ad_quo;
  ad_side_t    ad_so;

  // output register
  logic [12:0] acc_lim;
  logic [12:0] acc_d;
  logic        out_vld_q;
  logic [12:0] out_acc_q, out_dec_q;
  logic        out_safe_q;

  // ---------------------------------------------------------------- apb
  assign pready   = 1'b1;
  assign reg_idx  = reg_idx_e'(paddr[4:2]);
  assign mass_eff = (cfg_q.vehicle_mass == '0) ? 13'd1 : cfg_q.vehicle_mass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WHEEL_RADIUS:      cfg_q.wheel_radius      <= pwdata[10:0];
        REG_PEAK_POWER:        cfg_q.peak_power        <= pwdata[19:0];
        REG_PEAK_TORQUE:       cfg_q.peak_torque       <= pwdata[12:0];
        REG_ZERO_TORQUE_SPEED: cfg_q.zero_torque_speed <= pwdata[15:0];
        REG_POWER_LIMIT_SPEED: cfg_q.power_limit_speed <= pwdata[15:0];
        REG_DRAG_COEFFICIENT:  cfg_q.drag_coefficient  <= pwdata[15:0];
        REG_ROLLING_FORCE:     cfg_q.rolling_force     <= pwdata[12:0];
        REG_VEHICLE_MASS:      cfg_q.vehicle_mass      <= pwdata[12:0];
        default:               cfg_q                   <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WHEEL_RADIUS:      prdata = 32'(cfg_q.wheel_radius);
      REG_PEAK_POWER:        prdata = 32'(cfg_q.peak_power);
      REG_PEAK_TORQUE:       prdata = 32'(cfg_q.peak_torque);
      REG_ZERO_TORQUE_SPEED: prdata = 32'(cfg_q.zero_torque_speed);
      REG_POWER_LIMIT_SPEED: prdata = 32'(cfg_q.power_limit_speed);
      REG_DRAG_COEFFICIENT:  prdata = 32'(cfg_q.drag_coefficient);
      REG_ROLLING_FORCE:     prdata = 32'(cfg_q.rolling_force);
      REG_VEHICLE_MASS:      prdata = 32'(cfg_q.vehicle_mass);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // the pipe moves when the output register can take a result, or when the
  // last stage holds a bubble that may be dropped
  assign adv           = !ad_vld || !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- front end
  vadl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .cfg_i   (cfg_q),
    .speed_i (s_axis_tdata[15:0]),
    .curv_i  (s_axis_tdata[32:16]),
    .mu_i    (s_axis_tdata[41:33]),
    .acap_i  (s_axis_tdata[54:42]),
    .dcap_i  (s_axis_tdata[67:55]),
    .valid_o (fe_vld),
    .front_o (fe)
  );

  assign sq_si.num    = fe.num;
  assign sq_si.den    = fe.den;
  assign sq_si.resist = fe.resist;
  assign sq_si.safe   = fe.safe;
  assign sq_si.near   = fe.near;
  assign sq_si.fr24   = fe.fr24;
  assign sq_si.acap   = fe.acap;
  assign sq_si.dcap   = fe.dcap;

  // ---------------------------------------------------------------- friction root
  // root of fr24^2 - rad24^2, zero for an unsafe point
  vadl_sqrt_pipe #(
    .ROOT_W (29),
    .SIDE_W (SqSideW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fe_vld),
    .x_i     (fe.sqx),
    .side_i  (sq_si),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_so)
  );

  assign fd_si.root   = sq_root;
  assign fd_si.resist = sq_so.resist;
  assign fd_si.safe   = sq_so.safe;
  assign fd_si.near   = sq_so.near;
  assign fd_si.fr24   = sq_so.fr24;
  assign fd_si.acap   = sq_so.acap;
  assign fd_si.dcap   = sq_so.dcap;

  // ---------------------------------------------------------------- wheel force
  // the force quotient stays below 2^36 in every region, so the net force
  // never reaches the 2^40 - 1 ceiling
  vadl_div_pipe #(
    .NUM_W  (63),
    .DEN_W  (43),
    .Q_W    (36),
    .SIDE_W (FdSideW)
  ) u_force_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .num_i   (sq_so.num),
    .den_i   (sq_so.den),
    .side_i  (fd_si),
    .valid_o (fd_vld),
    .quo_o   (fd_quo),
    .side_o  (fd_so)
  );

  assign net_d = (fd_quo > 36'(fd_so.resist)) ? (fd_quo - 36'(fd_so.resist)) : '0;
  assign net_k = 46'(net_d) * 46'd1000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= fd_vld;
      m2_vld_q <= qd_vld;
      m3_vld_q <= m2_vld_q;
    end
  end

  // small forward limit, tight curve and no friction all force accel to zero
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q.net       <= net_d;
      m1_q.acc.gate  <= (net_k >= 46'({mass_eff, 8'd0})) && fd_so.near &&
                        (fd_so.fr24 != '0);
      m1_q.acc.decel <= !fd_so.safe ? 13'd0 :
                        (fd_so.root[28:16] < fd_so.dcap) ? fd_so.root[28:16] : fd_so.dcap;
      m1_q.acc.safe  <= fd_so.safe;
      m1_q.acc.acap  <= fd_so.acap;
      m1_q.acc.frcap <= fd_so.fr24[28:16];
      m1_num_q       <= {fd_so.root, 16'd0};
      m1_den_q       <= fd_so.fr24;
    end
  end

  // ---------------------------------------------------------------- friction ratio
  // q = root * 65536 / fr24, at most 65536
  vadl_div_pipe #(
    .NUM_W  (45),
    .DEN_W  (29),
    .Q_W    (17),
    .SIDE_W (QdSideW)
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m1_vld_q),
    .num_i   (m1_num_q),
    .den_i   (m1_den_q),
    .side_i  (m1_q),
    .valid_o (qd_vld),
    .quo_o   (qd_quo),
    .side_o  (qd_so)
  );

  // net * q, then the mass division with saturation at the output range
  assign x_d   = m2_prod_q[52:16];
  assign sat_d = x_d[36:13] >= 24'(mass_eff);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_prod_q <= 53'(qd_so.net) * 53'(qd_quo);
      m2_q      <= qd_so.acc;
      m3_num_q  <= sat_d ? 26'd0 : x_d[25:0];
      m3_q.sat  <= sat_d;
      m3_q.acc  <= m2_q;
    end
  end

  vadl_div_pipe #(
    .NUM_W  (26),
    .DEN_W  (13),
    .Q_W    (13),
    .SIDE_W (AdSideW)
  ) u_mass_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m3_vld_q),
    .num_i   (m3_num_q),
    .den_i   (mass_eff),
    .side_i  (m3_q),
    .valid_o (ad_vld),
    .quo_o   (ad_quo),
    .side_o  (ad_so)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    acc_lim = ad_so.sat ? OutMax : ad_quo;
    if (ad_so.acc.acap < acc_lim) begin
      acc_lim = ad_so.acc.acap;
    end
    if (ad_so.acc.frcap < acc_lim) begin
      acc_lim = ad_so.acc.frcap;
    end
    acc_d = ad_so.acc.gate ? acc_lim : 13'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= ad_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_acc_q  <= acc_d;
      out_dec_q  <= ad_so.acc.decel;
      out_safe_q <= ad_so.acc.safe;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_safe_q, out_dec_q, out_acc_q};

  // ---------------------------------------------------------------- checks
  a_unsafe_no_decel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_safe_q |-> out_dec_q == '0)
    else $error("braking limit nonzero on an unsafe point");

  a_last_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ad_vld && out_vld_q && !m_axis_tready |=> ad_vld)
    else $error("result lost at the end of the pipe");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_vld_q && ad_vld && !m_axis_tready)
    else $error("request stalled without a blocked result");

endmodule

`default_nettype wire

/* tb/tb_vehicle_accel_decel_limits_core.sv */
// self-checking testbench for the acceleration and braking limit block
`timescale 1ns / 100ps
`default_nettype none

module tb_vehicle_accel_decel_limits_core;
  import vadl_pkg::*;

  typedef struct packed {
    logic [12:0] max_accel;
    logic [12:0] max_decel;
    logic        braking_safe;
  } limits_t;

  // predicted limits waiting for the block, oldest first
  class limits_board;
    limits_t pending[$];
    int      errors;

    function void note(limits_t l);
      pending.push_back(l);
    endfunction

    function void check(logic [31:0] word);
      limits_t got;
      limits_t want;
      got.max_accel    = word[12:0];
      got.max_decel    = word[25:13];
      got.braking_safe = word[26];
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, word);
        return;
      end
      want = pending.pop_front();
      if (got.max_accel !== want.max_accel) begin
        errors++;
        $display("%0t: max_accel expected %0d actual %0d", $realtime,
                 want.max_accel, got.max_accel);
      end
      if (got.max_decel !== want.max_decel) begin
        errors++;
        $display("%0t: max_decel expected %0d actual %0d", $realtime,
                 want.max_decel, got.max_decel);
      end
      if (got.braking_safe !== want.braking_safe) begin
        errors++;
        $display("%0t: braking_safe expected %0d actual %0d", $realtime,
                 want.braking_safe, got.braking_safe);
      end
      if (word[31:27] !== 5'd0) begin
        errors++;
        $display("%0t: pad bits expected 0 actual %b", $realtime, word[31:27]);
      end
    endfunction
  endclass

  localparam int Latency = 104;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  cfg_t        cfg = CfgReset;
  limits_board board = new();
  bit          sink_busy = 1'b1;

  always #6 clk_i = ~clk_i;

  vehicle_accel_decel_limits_core DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // friction circle limits for one trajectory point under the current registers
  function automatic limits_t predict_limits(logic [71:0] req);
    logic [63:0] s, k, mu, acap, dcap, r, m, a, bn, bm;
    logic [63:0] pp, pt, zn, zm, dc, rf;
    logic [63:0] force_q8, resist, net, rad32, fr24, fr32, rad24, root, q, acc, dec;
    logic [16:0] curv;
    bit          safe;
    limits_t     l;
    s    = 64'(req[15:0]);
    curv = req[32:16];
    mu   = 64'(req[41:33]);
    acap = 64'(req[54:42]);
    dcap = 64'(req[67:55]);
    pp   = 64'(cfg.peak_power);
    pt   = 64'(cfg.peak_torque);
    zn   = 64'(cfg.zero_torque_speed);
    zm   = 64'(cfg.power_limit_speed);
    dc   = 64'(cfg.drag_coefficient);
    rf   = 64'(cfg.rolling_force);
    r    = (cfg.wheel_radius != '0) ? 64'(cfg.wheel_radius) : 64'd1;
    m    = (cfg.vehicle_mass != '0) ? 64'(cfg.vehicle_mass) : 64'd1;
    k    = curv[16] ? (64'h20000 - 64'(curv)) : 64'(curv);
    a    = 64'd64 * s;
    bn   = zn * r;
    bm   = zm * r;
    acc  = '0;
    dec  = '0;
    // torque curve: flat torque, constant power, linear taper, nothing
    if (a >= bn) force_q8 = '0;
    else if (s == '0) force_q8 = (pt << 18) / r;
    else if (a >= bm) force_q8 = ((pp * (bn - a)) << 16) / (s * (zn - zm) * r);
    else if (pp * r >= 64'd4 * s * pt) force_q8 = (pt << 18) / r;
    else force_q8 = (pp << 16) / s;
    resist = ((dc * s * s) >> 24) + rf * 64'd256;
    net = force_q8 > resist ? force_q8 - resist : '0;
    if (net > 64'hFF_FFFF_FFFF) net = 64'hFF_FFFF_FFFF;
    rad32 = k * s * s;
    fr24  = mu * 64'(GravQ16);
    fr32  = fr24 << 8;
    safe  = rad32 <= fr32;
    rad24 = rad32 >> 8;
    root  = safe ? int_sqrt((fr24 - rad24) * (fr24 + rad24)) : 64'd0;
    if (safe) dec = (root >> 16) < dcap ? (root >> 16) : dcap;
    // tiny forward limit, curve too tight and no friction all force zero
    if (64'd1000 * net >= 64'd256 * m && rad32 <= fr32 + 64'(EpsQ32) && fr24 != '0) begin
      q   = (root << 16) / fr24;
      acc = (net * q) / (m << 16);
      if (acc > acap) acc = acap;
      if (acc > (fr24 >> 16)) acc = fr24 >> 16;
    end
    l.max_accel    = acc > 64'(OutMax) ? OutMax : acc[12:0];
    l.max_decel    = dec > 64'(OutMax) ? OutMax : dec[12:0];
    l.braking_safe = safe;
    return l;
  endfunction

  // apb write: setup then access, mirrored into the local copy
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= 5'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WHEEL_RADIUS:      cfg.wheel_radius      = value[10:0];
      REG_PEAK_POWER:        cfg.peak_power        = value[19:0];
      REG_PEAK_TORQUE:       cfg.peak_torque       = value[12:0];
      REG_ZERO_TORQUE_SPEED: cfg.zero_torque_speed = value[15:0];
      REG_POWER_LIMIT_SPEED: cfg.power_limit_speed = value[15:0];
      REG_DRAG_COEFFICIENT:  cfg.drag_coefficient  = value[15:0];
      REG_ROLLING_FORCE:     cfg.rolling_force     = value[12:0];
      default:               cfg.vehicle_mass      = value[12:0];
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(REG_WHEEL_RADIUS, 32'(c.wheel_radius));
    write_reg(REG_PEAK_POWER, 32'(c.peak_power));
    write_reg(REG_PEAK_TORQUE, 32'(c.peak_torque));
    write_reg(REG_ZERO_TORQUE_SPEED, 32'(c.zero_torque_speed));
    write_reg(REG_POWER_LIMIT_SPEED, 32'(c.power_limit_speed));
    write_reg(REG_DRAG_COEFFICIENT, 32'(c.drag_coefficient));
    write_reg(REG_ROLLING_FORCE, 32'(c.rolling_force));
    write_reg(REG_VEHICLE_MASS, 32'(c.vehicle_mass));
  endtask

  // one request, with a random gap ahead of it when idling is on
  task automatic send_point(logic [15:0] spd, logic [16:0] curv, logic [8:0] mu,
                            logic [12:0] acap, logic [12:0] dcap, bit gaps);
    logic [71:0] req;
    req = {4'd0, dcap, acap, mu, curv, spd};
    if (gaps) begin
      while ($urandom_range(99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note(predict_limits(req));
  endtask

  task automatic send_random(bit gaps);
    logic [15:0] spd;
    logic [16:0] curv;
    case ($urandom_range(3))
      0: spd = 16'($urandom);
      1: spd = 16'($urandom_range(2048));
      default: spd = 16'($urandom_range(12000));
    endcase
    // mostly gentle curves so the friction budget is not always blown
    case ($urandom_range(3))
      0: curv = 17'($urandom);
      1: curv = 17'h0;
      default: curv = 17'($signed($urandom_range(400)) - 200);
    endcase
    send_point(spd, curv, 9'($urandom), 13'($urandom), 13'($urandom), gaps);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // result side: random backpressure apart from a quiet window
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
    m_axis_tready <= sink_busy ? ($urandom_range(99) >= 37) : 1'b1;
  end

  initial begin
    cfg_t c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and the named corner cases at reset settings
    send_point(16'd0, 17'd0, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'hFFFF, 17'h1FFFF, 9'd511, 13'd8191, 13'd8191, 0);
    send_point(16'd2560, 17'h10000, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd2560, 17'd0, 9'd0, 13'd8191, 13'd8191, 0);
    send_point(16'd256, 17'd0, 9'd511, 13'd0, 13'd0, 0);
    send_point(16'd5000, 17'd0, 9'd256, 13'd100, 13'd100, 0);
    send_point(16'd12000, 17'd0, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd16000, 17'd0, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd30000, 17'd0, 9'd256, 13'd8191, 13'd8191, 0);
    // curvatures 6278, 6279 and -6279, all inside the friction budget at this speed
    send_point(16'd2560, 17'd6278, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd2560, 17'd6279, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd2560, 17'h1E779, 9'd256, 13'd8191, 13'd8191, 0);
    send_point(16'd1, 17'h0FFFF, 9'd1, 13'd1, 13'd1, 0);
    // pause until the pipe is empty
    drain_and_settle();

    // extremes: tiny mass and radius, huge torque, full-scale speed settings
    load_cfg('{wheel_radius: 11'd0, peak_power: 20'hFFFFF, peak_torque: 13'h1FFF,
               zero_torque_speed: 16'hFFFF, power_limit_speed: 16'hFFFF,
               drag_coefficient: 16'd0, rolling_force: 13'd0, vehicle_mass: 13'd0});
    send_point(16'd0, 17'd0, 9'd511, 13'd8191, 13'd8191, 0);
    send_point(16'd100, 17'd0, 9'd511, 13'd8191, 13'd8191, 0);
    for (int i = 0; i < 150; i++) send_random(1);
    drain_and_settle();

    load_cfg('{wheel_radius: 11'h7FF, peak_power: 20'd0, peak_torque: 13'd0,
               zero_torque_speed: 16'd0, power_limit_speed: 16'd0,
               drag_coefficient: 16'hFFFF, rolling_force: 13'h1FFF,
               vehicle_mass: 13'h1FFF});
    send_point(16'd0, 17'd0, 9'd256, 13'd8191, 13'd8191, 0);
    for (int i = 0; i < 100; i++) send_random(1);
    drain_and_settle();

    // random settings, reset settings in the last phase, no idling in the first phase
    for (int p = 0; p < 6; p++) begin
      c.wheel_radius      = 11'($urandom_range(2047, 100));
      c.peak_power        = 20'($urandom);
      c.peak_torque       = 13'($urandom);
      c.zero_torque_speed = 16'($urandom);
      c.power_limit_speed = 16'($urandom_range(c.zero_torque_speed));
      c.drag_coefficient  = 16'($urandom);
      c.rolling_force     = 13'($urandom_range(1000));
      c.vehicle_mass      = 13'($urandom_range(8191, 1));
      if (p == 5) c = CfgReset;
      load_cfg(c);
      sink_busy = (p != 0);
      for (int i = 0; i < 145; i++) send_random(p != 0);
      drain_and_settle();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("vehicle_accel_decel_limits_core regression: pass");
    else
      $display("vehicle_accel_decel_limits_core regression: fail");
    $finish;
  end

  initial begin
    #(12ns * 400000);
    $display("vehicle_accel_decel_limits_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
